@@ rtl/chr_pkg.sv @@
// shared types, constants, control store and helpers for the cascaded rolling history
`default_nettype none

package chr_pkg;

	localparam int unsigned SLOTS_DEFAULT = 60;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned PEAK_W = 31;
	localparam int unsigned DIV_BITS = 8;
	localparam int unsigned DIV_STEPS = TIME_W / DIV_BITS;
	localparam int unsigned NUM_RINGS = 4;
	localparam int unsigned RING_W = 2;
	localparam int unsigned UPC_W = 5;

	localparam logic [RING_W-1:0] RING_TICK = RING_W'(0);
	localparam logic [RING_W-1:0] RING_HOUR = RING_W'(NUM_RINGS - 1);

	typedef enum logic [2:0] {
		MODE_SET     = 3'd0,
		MODE_ADD     = 3'd1,
		MODE_SET_UPD = 3'd2,
		MODE_UPD     = 3'd3,
		MODE_READ    = 3'd4,
		MODE_CLEAR   = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_DIGIT,
		OP_CLEAR,
		OP_WR_ADD,
		OP_WR_SET,
		OP_RING_INIT,
		OP_SCAN,
		OP_PEAK,
		OP_AGG,
		OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		COND_NEXT,
		COND_GOTO,
		COND_WAIT,
		COND_LOOP,
		COND_DIG_MORE,
		COND_NOT_CLR,
		COND_NOT_ADD,
		COND_NOT_SET,
		COND_NOT_UPD,
		COND_RING_LAST
	} cond_t;

	typedef logic [UPC_W-1:0] upc_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
	} ucw_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	typedef struct packed {
		logic clr;
		logic we;
	} ring_ctl_t;

	localparam upc_t UPC_IDLE     = upc_t'(0);
	localparam upc_t UPC_LOAD     = upc_t'(1);
	localparam upc_t UPC_DIV      = upc_t'(2);
	localparam upc_t UPC_DIGIT    = upc_t'(3);
	localparam upc_t UPC_CLR_TST  = upc_t'(4);
	localparam upc_t UPC_CLEAR    = upc_t'(5);
	localparam upc_t UPC_ADD_TST  = upc_t'(6);
	localparam upc_t UPC_ADD      = upc_t'(7);
	localparam upc_t UPC_SET_TST  = upc_t'(8);
	localparam upc_t UPC_SET      = upc_t'(9);
	localparam upc_t UPC_UPD_TST  = upc_t'(10);
	localparam upc_t UPC_SCAN     = upc_t'(11);
	localparam upc_t UPC_DRAIN    = upc_t'(12);
	localparam upc_t UPC_PEAK     = upc_t'(13);
	localparam upc_t UPC_AGG_DIV  = upc_t'(14);
	localparam upc_t UPC_AGG      = upc_t'(15);
	localparam upc_t UPC_RD       = upc_t'(16);
	localparam upc_t UPC_OUT      = upc_t'(17);

	// control store: one word per step
	function automatic ucw_t ucode(input upc_t pc);
		ucw_t w;
		w = '{OP_NOP, COND_GOTO, UPC_IDLE};
		unique case (pc)
			UPC_IDLE:    w = '{OP_NOP,       COND_WAIT,      UPC_IDLE};
			UPC_LOAD:    w = '{OP_DIV_LOAD,  COND_NEXT,      UPC_IDLE};
			UPC_DIV:     w = '{OP_DIV_STEP,  COND_LOOP,      UPC_DIV};
			UPC_DIGIT:   w = '{OP_DIGIT,     COND_DIG_MORE,  UPC_DIV};
			UPC_CLR_TST: w = '{OP_NOP,       COND_NOT_CLR,   UPC_ADD_TST};
			UPC_CLEAR:   w = '{OP_CLEAR,     COND_GOTO,      UPC_RD};
			UPC_ADD_TST: w = '{OP_NOP,       COND_NOT_ADD,   UPC_SET_TST};
			UPC_ADD:     w = '{OP_WR_ADD,    COND_GOTO,      UPC_RD};
			UPC_SET_TST: w = '{OP_NOP,       COND_NOT_SET,   UPC_UPD_TST};
			UPC_SET:     w = '{OP_WR_SET,    COND_NEXT,      UPC_IDLE};
			UPC_UPD_TST: w = '{OP_RING_INIT, COND_NOT_UPD,   UPC_RD};
			UPC_SCAN:    w = '{OP_SCAN,      COND_LOOP,      UPC_SCAN};
			UPC_DRAIN:   w = '{OP_NOP,       COND_NEXT,      UPC_IDLE};
			UPC_PEAK:    w = '{OP_PEAK,      COND_RING_LAST, UPC_RD};
			UPC_AGG_DIV: w = '{OP_DIV_STEP,  COND_LOOP,      UPC_AGG_DIV};
			UPC_AGG:     w = '{OP_AGG,       COND_GOTO,      UPC_SCAN};
			UPC_RD:      w = '{OP_NOP,       COND_NEXT,      UPC_IDLE};
			UPC_OUT:     w = '{OP_OUT,       COND_GOTO,      UPC_IDLE};
			default:     w = '{OP_NOP,       COND_GOTO,      UPC_IDLE};
		endcase
		return w;
	endfunction

	// clamp a wide signed value into the q16.16 range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [TIME_W-1:0] x);
		logic signed [TIME_W-1:0] hi;
		logic signed [TIME_W-1:0] lo;
		hi = TIME_W'({1'b0, {(DATA_W-1){1'b1}}});
		lo = -hi - TIME_W'(1);
		if (x > hi) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end else if (x < lo) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return x[DATA_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/chr_div.sv @@
// shift-subtract divider by the slot count, several quotient bits per cycle while it is stepped
`default_nettype none

module chr_div import chr_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
	input  logic                             clk,
	input  div_ctl_t                         ctl,
	input  logic [TIME_W-1:0]                din,
	output logic [TIME_W-1:0]                quo,
	output logic [$clog2(SLOTS)-1:0]         rem
);

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W:0] SLOTS_V = (IDX_W+1)'(SLOTS);

	logic [TIME_W-1:0] quo_q;
	logic [IDX_W-1:0]  rem_q;
	logic [TIME_W-1:0] d;
	logic [IDX_W-1:0]  r;
	logic [IDX_W:0]    trial;

	always_comb begin
		d = quo_q;
		r = rem_q;
		trial = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {r, d[TIME_W-1]};
			d = {d[TIME_W-2:0], 1'b0};
			if (trial >= SLOTS_V) begin
				d[0] = 1'b1;
				r = IDX_W'(trial - SLOTS_V);
			end else begin
				r = trial[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_q <= din;
			rem_q <= '0;
		end else if (ctl.step) begin
			quo_q <= d;
			rem_q <= r;
		end
	end

	assign quo = quo_q;
	assign rem = rem_q;

endmodule

`default_nettype wire

@@ rtl/chr_ring.sv @@
// one ring of q16.16 slots with per-slot valid bits and a registered read port
`default_nettype none

module chr_ring import chr_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ring_ctl_t                   ctl,
	input  logic [$clog2(SLOTS)-1:0]    waddr,
	input  logic signed [DATA_W-1:0]    wdata,
	input  logic [$clog2(SLOTS)-1:0]    raddr,
	output logic signed [DATA_W-1:0]    rdata
);

	logic signed [DATA_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0]         vld_q;
	logic signed [DATA_W-1:0] rd_q;
	logic                     rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// a slot never written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[raddr];
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ rtl/cascaded_rolling_history.sv @@
// top level: microcoded sequencer over four history rings and a shared divider
//
//  channel   signals                                  beat taken when
//  -------   --------------------------------------   ---------------------
//  command   start, busy, mode, time_req, value       start & !busy
//  config    cfg_valid, cfg_ready, cfg_data           cfg_valid & cfg_ready
//  result    done, slot_value, *_peak, is_empty       done (one cycle)
//
// a command runs as a program in the control store, one step per cycle
// update commands scan each ring one slot a cycle through its single read port
// other commands are mostly four digit extractions of time_req at
//   8 quotient bits a cycle
// reset takes effect at once (per-slot valid bits, no sweep); results cannot be stalled
`default_nettype none

module cascaded_rolling_history import chr_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                mode,
	input  logic [TIME_W-1:0]         time_req,
	input  logic signed [DATA_W-1:0]  value,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,
	output logic                      done,
	output logic signed [DATA_W-1:0]  slot_value,
	output logic [PEAK_W-1:0]         tick_peak,
	output logic [PEAK_W-1:0]         second_peak,
	output logic [PEAK_W-1:0]         minute_peak,
	output logic [PEAK_W-1:0]         hour_peak,
	output logic                      is_empty
);

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned CNT_MAX = (SLOTS > DIV_STEPS) ? SLOTS : DIV_STEPS;
	localparam int unsigned CNT_W = $clog2(CNT_MAX);
	localparam int unsigned SUM_W = DATA_W + IDX_W;

	upc_t                     pc_q;
	upc_t                     pc_nx;
	upc_t                     pc_inc;
	ucw_t                     uc;
	logic                     accept;

	logic [2:0]               mode_q;
	logic [TIME_W-1:0]        t_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     sum_mode_q;

	logic [IDX_W-1:0]         dig_q [NUM_RINGS];
	logic [RING_W-1:0]        di_q;
	logic [RING_W-1:0]        ring_q;
	logic [RING_W-1:0]        ring_nx1;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_nx;
	logic                     cnt_last;

	logic                     rd_pend_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [PEAK_W-1:0]        max_q;
	logic [PEAK_W-1:0]        peak_q [NUM_RINGS];
	logic                     done_q;
	logic signed [DATA_W-1:0] slot_q;

	div_ctl_t                 div_ctl;
	logic [TIME_W-1:0]        div_din;
	logic [TIME_W-1:0]        div_quo;
	logic [IDX_W-1:0]         div_rem;

	ring_ctl_t                ring_ctl [NUM_RINGS];
	logic [IDX_W-1:0]         ring_waddr;
	logic [IDX_W-1:0]         ring_raddr;
	logic signed [DATA_W-1:0] ring_wdata;
	logic signed [DATA_W-1:0] ring_rdata [NUM_RINGS];
	logic signed [DATA_W-1:0] scan_data;

	logic [SUM_W-1:0]         sum_mag;
	logic signed [TIME_W-1:0] quo_wide;
	logic signed [TIME_W-1:0] add_wide;
	logic signed [TIME_W-1:0] agg_wide;
	logic signed [DATA_W-1:0] add_val;
	logic signed [DATA_W-1:0] agg_val;

	assign uc = ucode(pc_q);
	assign busy = (pc_q != UPC_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = !busy;
	assign pc_inc = pc_q + upc_t'(1);
	assign ring_nx1 = ring_q + RING_W'(1);

	assign cnt_last = (uc.op == OP_SCAN) ? (cnt_q == CNT_W'(SLOTS - 1))
	                                     : (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign cnt_nx = ((uc.cond == COND_LOOP) && !cnt_last) ? cnt_q + CNT_W'(1) : '0;

	// sequencer: next step
	always_comb begin
		pc_nx = pc_inc;
		unique case (uc.cond)
			COND_NEXT:      pc_nx = pc_inc;
			COND_GOTO:      pc_nx = uc.target;
			COND_WAIT:      pc_nx = start ? pc_inc : uc.target;
			COND_LOOP:      pc_nx = cnt_last ? pc_inc : uc.target;
			COND_DIG_MORE:  pc_nx = (di_q != RING_HOUR) ? uc.target : pc_inc;
			COND_NOT_CLR:   pc_nx = (mode_q != MODE_CLEAR) ? uc.target : pc_inc;
			COND_NOT_ADD:   pc_nx = (mode_q != MODE_ADD) ? uc.target : pc_inc;
			COND_NOT_SET:   pc_nx = ((mode_q != MODE_SET) && (mode_q != MODE_SET_UPD))
			                        ? uc.target : pc_inc;
			COND_NOT_UPD:   pc_nx = ((mode_q != MODE_UPD) && (mode_q != MODE_SET_UPD))
			                        ? uc.target : pc_inc;
			COND_RING_LAST: pc_nx = (ring_q == RING_HOUR) ? uc.target : pc_inc;
			default:        pc_nx = UPC_IDLE;
		endcase
	end

	// datapath arithmetic
	assign scan_data = ring_rdata[ring_q];
	assign add_wide = TIME_W'(ring_rdata[RING_TICK]) + TIME_W'(value_q);
	assign add_val = sat32(add_wide);
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign quo_wide = $signed(div_quo);
	assign agg_wide = sum_mode_q ? TIME_W'(sum_q)
	                             : (sum_q[SUM_W-1] ? -quo_wide : quo_wide);
	assign agg_val = sat32(agg_wide);

	// control word decode
	always_comb begin
		div_ctl.load = (uc.op == OP_DIV_LOAD) || (uc.op == OP_DIGIT) || (uc.op == OP_PEAK);
		div_ctl.step = (uc.op == OP_DIV_STEP);
		unique case (uc.op)
			OP_DIGIT: div_din = div_quo;
			OP_PEAK:  div_din = TIME_W'(sum_mag);
			default:  div_din = t_q;
		endcase

		for (int g = 0; g < NUM_RINGS; g++) begin
			ring_ctl[g].clr = (uc.op == OP_CLEAR);
			ring_ctl[g].we = (((uc.op == OP_WR_SET) || (uc.op == OP_WR_ADD)) &&
			                  (RING_W'(g) == RING_TICK)) ||
			                 ((uc.op == OP_AGG) && (ring_nx1 == RING_W'(g)));
		end

		ring_waddr = (uc.op == OP_AGG) ? dig_q[ring_nx1] : dig_q[RING_TICK];
		ring_raddr = (uc.op == OP_SCAN) ? cnt_q[IDX_W-1:0] : dig_q[RING_TICK];
		unique case (uc.op)
			OP_WR_SET: ring_wdata = value_q;
			OP_WR_ADD: ring_wdata = add_val;
			default:   ring_wdata = agg_val;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UPC_IDLE;
			cnt_q <= '0;
			di_q <= '0;
			ring_q <= '0;
			rd_pend_q <= 1'b0;
			done_q <= 1'b0;
			sum_mode_q <= 1'b0;
			for (int k = 0; k < NUM_RINGS; k++) begin
				peak_q[k] <= '0;
			end
		end else begin
			pc_q <= pc_nx;
			cnt_q <= cnt_nx;
			rd_pend_q <= (uc.op == OP_SCAN);
			done_q <= (uc.op == OP_OUT);
			if (uc.op == OP_DIV_LOAD) begin
				di_q <= '0;
			end else if (uc.op == OP_DIGIT) begin
				di_q <= di_q + RING_W'(1);
			end
			if (uc.op == OP_RING_INIT) begin
				ring_q <= RING_TICK;
			end else if (uc.op == OP_AGG) begin
				ring_q <= ring_nx1;
			end
			if (cfg_valid && cfg_ready) begin
				sum_mode_q <= cfg_data;
			end
			if (uc.op == OP_CLEAR) begin
				for (int k = 0; k < NUM_RINGS; k++) begin
					peak_q[k] <= '0;
				end
			end else if (uc.op == OP_PEAK) begin
				peak_q[ring_q] <= max_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			t_q <= time_req;
			value_q <= value;
		end
		if (uc.op == OP_DIGIT) begin
			dig_q[di_q] <= div_rem;
		end
		// read data arrives in the cycle after its scan address
		if ((uc.op == OP_SCAN) && (cnt_q == '0)) begin
			sum_q <= '0;
			max_q <= '0;
		end else if (rd_pend_q) begin
			sum_q <= sum_q + SUM_W'(scan_data);
			if (scan_data > $signed({1'b0, max_q})) begin
				max_q <= scan_data[PEAK_W-1:0];
			end
		end
		if (uc.op == OP_OUT) begin
			slot_q <= ring_rdata[RING_TICK];
		end
	end

	chr_div #(
		.SLOTS (SLOTS)
	) u_div (
		.clk (clk),
		.ctl (div_ctl),
		.din (div_din),
		.quo (div_quo),
		.rem (div_rem)
	);

	for (genvar g = 0; g < NUM_RINGS; g++) begin : g_ring
		chr_ring #(
			.SLOTS (SLOTS)
		) u_ring (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ring_ctl[g]),
			.waddr  (ring_waddr),
			.wdata  (ring_wdata),
			.raddr  (ring_raddr),
			.rdata  (ring_rdata[g])
		);
	end

	assign done = done_q;
	assign slot_value = slot_q;
	assign tick_peak = peak_q[0];
	assign second_peak = peak_q[1];
	assign minute_peak = peak_q[2];
	assign hour_peak = peak_q[3];
	assign is_empty = (peak_q[0] == '0) && (peak_q[1] == '0) &&
	                  (peak_q[2] == '0) && (peak_q[3] == '0);

endmodule

`default_nettype wire

@@ rtl/chr_chk.sv @@
// port-level checks on the cascaded rolling history, bound to the top level
`default_nettype none

module chr_chk import chr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [PEAK_W-1:0] tick_peak,
	input logic [PEAK_W-1:0] second_peak,
	input logic [PEAK_W-1:0] minute_peak,
	input logic [PEAK_W-1:0] hour_peak,
	input logic              is_empty
);

	// a result beat only appears once the command has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// every accepted command makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted but block not busy");

	// a command ends with exactly one result beat
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("command ended without a result beat");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		is_empty == ((tick_peak == '0) && (second_peak == '0) &&
		             (minute_peak == '0) && (hour_peak == '0)))
		else $error("is_empty disagrees with the peaks");

endmodule

bind cascaded_rolling_history chr_chk u_chk (.*);

`default_nettype wire

@@ verif/tb.sv @@
// testbench for cascaded_rolling_history: directed command table, then random commands
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import chr_pkg::*;

	localparam int unsigned NSLOT = SLOTS_DEFAULT;
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef struct packed {
		logic signed [DATA_W-1:0] slot;
		logic [PEAK_W-1:0]        tick_pk;
		logic [PEAK_W-1:0]        sec_pk;
		logic [PEAK_W-1:0]        minute_pk;
		logic [PEAK_W-1:0]        hour_pk;
		logic                     empty;
	} outcome_t;

	typedef struct {
		bit                  cfg;
		logic [2:0]          op;
		logic [TIME_W-1:0]   at;
		logic [DATA_W-1:0]   val;
		bit                  typed;
		outcome_t            want;
	} plan_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic [2:0]                mode = '0;
	logic [TIME_W-1:0]         time_req = '0;
	logic signed [DATA_W-1:0]  value = '0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_data = 1'b0;
	logic                      busy;
	logic                      cfg_ready;
	logic                      done;
	logic signed [DATA_W-1:0]  slot_value;
	logic [PEAK_W-1:0]         tick_peak;
	logic [PEAK_W-1:0]         second_peak;
	logic [PEAK_W-1:0]         minute_peak;
	logic [PEAK_W-1:0]         hour_peak;
	logic                      is_empty;

	// predictor state: tick, second, minute, hour rings and their floored maxima
	logic signed [DATA_W-1:0]  hist [NUM_RINGS][NSLOT];
	logic signed [DATA_W-1:0]  peak [NUM_RINGS];
	bit                        agg_sum;
	outcome_t                  pending_results[$];
	int unsigned               mismatch_count = 0;

	cascaded_rolling_history u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.time_req    (time_req),
		.value       (value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.slot_value  (slot_value),
		.tick_peak   (tick_peak),
		.second_peak (second_peak),
		.minute_peak (minute_peak),
		.hour_peak   (hour_peak),
		.is_empty    (is_empty)
	);

	always #10 clk = ~clk;

	function automatic logic signed [DATA_W-1:0] clamp_q(longint x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return DATA_W'(x);
	endfunction

	// applies one command to the history model and returns its result
	function automatic outcome_t history_step(logic [2:0] op, logic [TIME_W-1:0] at,
			logic signed [DATA_W-1:0] val);
		int unsigned              slot;
		logic [TIME_W-1:0]        digits;
		longint                   total;
		logic signed [DATA_W-1:0] top;
		outcome_t                 r;
		slot = at % NSLOT;
		case (op)
			MODE_SET, MODE_SET_UPD: hist[RING_TICK][slot] = val;
			MODE_ADD: hist[RING_TICK][slot] =
				clamp_q(longint'(hist[RING_TICK][slot]) + longint'(val));
			MODE_CLEAR: begin
				for (int k = 0; k < NUM_RINGS; k++) begin
					peak[k] = '0;
					for (int i = 0; i < NSLOT; i++) hist[k][i] = '0;
				end
			end
			default: ;
		endcase
		if (op == MODE_SET_UPD || op == MODE_UPD) begin
			digits = at;
			for (int k = 0; k < NUM_RINGS; k++) begin
				total = 0;
				top = '0;
				for (int i = 0; i < NSLOT; i++) begin
					total += hist[k][i];
					if (hist[k][i] > top) top = hist[k][i];
				end
				peak[k] = top;
				// aggregate lands in the next coarser ring at the next time digit
				if (k < NUM_RINGS - 1) begin
					digits = digits / NSLOT;
					hist[k+1][digits % NSLOT] =
						agg_sum ? clamp_q(total) : clamp_q(total / longint'(NSLOT));
				end
			end
		end
		r.slot = hist[RING_TICK][slot];
		r.tick_pk = peak[0][PEAK_W-1:0];
		r.sec_pk = peak[1][PEAK_W-1:0];
		r.minute_pk = peak[2][PEAK_W-1:0];
		r.hour_pk = peak[3][PEAK_W-1:0];
		r.empty = (peak[0] == 0 && peak[1] == 0 && peak[2] == 0 && peak[3] == 0);
		return r;
	endfunction

	task automatic send_cmd(logic [2:0] op, logic [TIME_W-1:0] at, logic [DATA_W-1:0] val,
			bit typed, outcome_t want, bit flat);
		int unsigned gap;
		outcome_t    got;
		gap = 0;
		if (!flat) begin
			gap = $urandom_range(0, 9);
			if (gap < 6) gap = 0;
			else if (gap < 9) gap = $urandom_range(1, 3);
			else gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= op;
		time_req <= at;
		value <= val;
		do @(posedge clk); while (busy);
		got = history_step(op, at, val);
		pending_results.push_back(typed ? want : got);
	endtask

	// register writes only once every command has reported back
	task automatic write_sum_mode(bit b);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		agg_sum = b;
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no command pending");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (slot_value !== want.slot) begin
					$error("slot_value: expected %h, got %h", want.slot, slot_value);
					mismatch_count++;
				end
				if (tick_peak !== want.tick_pk) begin
					$error("tick_peak: expected %h, got %h", want.tick_pk, tick_peak);
					mismatch_count++;
				end
				if (second_peak !== want.sec_pk) begin
					$error("second_peak: expected %h, got %h", want.sec_pk, second_peak);
					mismatch_count++;
				end
				if (minute_peak !== want.minute_pk) begin
					$error("minute_peak: expected %h, got %h", want.minute_pk, minute_peak);
					mismatch_count++;
				end
				if (hour_peak !== want.hour_pk) begin
					$error("hour_peak: expected %h, got %h", want.hour_pk, hour_peak);
					mismatch_count++;
				end
				if (is_empty !== want.empty) begin
					$error("is_empty: expected %b, got %b", want.empty, is_empty);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		plan_row_t         plan[$];
		bit                flat;
		logic [2:0]        op;
		logic [TIME_W-1:0] at;
		logic [DATA_W-1:0] val;
		int unsigned       pick;
		agg_sum = 1'b0;
		void'(history_step(MODE_CLEAR, '0, '0));

		// cfg, op, time, value, typed, expected result
		plan.push_back('{0, MODE_READ, 48'd0, 32'h0, 1, '{32'h0, '0, '0, '0, '0, 1'b1}});
		plan.push_back('{0, MODE_SET, 48'd0, 32'h7fffffff, 1,
			'{32'h7fffffff, '0, '0, '0, '0, 1'b1}});
		// add saturates high, then low
		plan.push_back('{0, MODE_ADD, 48'd60, 32'h1, 1, '{32'h7fffffff, '0, '0, '0, '0, 1'b1}});
		plan.push_back('{0, MODE_SET, 48'd1, 32'h80000000, 1,
			'{32'h80000000, '0, '0, '0, '0, 1'b1}});
		plan.push_back('{0, MODE_ADD, 48'd61, 32'hffffffff, 1,
			'{32'h80000000, '0, '0, '0, '0, 1'b1}});
		plan.push_back('{0, MODE_ADD, 48'd2, 32'h00010000, 1,
			'{32'h00010000, '0, '0, '0, '0, 1'b1}});
		plan.push_back('{0, MODE_UPD, 48'd0, 32'h0, 0, '0});
		plan.push_back('{0, MODE_SET_UPD, 48'hffff_ffff_ffff, 32'h7fffffff, 0, '0});
		plan.push_back('{0, MODE_SPARE_LO, 48'h8000_0000_0000, 32'h12345678, 0, '0});
		plan.push_back('{0, MODE_SPARE_HI, 48'd123, 32'hdeadbeef, 0, '0});
		// maxima stay stale until the next update
		plan.push_back('{0, MODE_SET, 48'd59, 32'hfffffffb, 0, '0});
		plan.push_back('{0, MODE_CLEAR, 48'd59, 32'h0, 1, '{32'h0, '0, '0, '0, '0, 1'b1}});
		plan.push_back('{0, MODE_SET_UPD, 48'd59, 32'hfffffffb, 0, '0});
		plan.push_back('{1, MODE_READ, 48'd0, 32'h1, 0, '0});
		plan.push_back('{0, MODE_SET, 48'd0, 32'h7fffffff, 0, '0});
		plan.push_back('{0, MODE_SET_UPD, 48'd1, 32'h7fffffff, 0, '0});
		plan.push_back('{0, MODE_UPD, 48'd215999, 32'h0, 0, '0});
		plan.push_back('{0, MODE_SET, 48'd2, 32'h80000000, 0, '0});
		plan.push_back('{0, MODE_SET, 48'd3, 32'h80000000, 0, '0});
		plan.push_back('{0, MODE_SET_UPD, 48'd4, 32'h80000000, 0, '0});
		plan.push_back('{1, MODE_READ, 48'd0, 32'h0, 0, '0});
		plan.push_back('{0, MODE_CLEAR, 48'd7, 32'h0, 1, '{32'h0, '0, '0, '0, '0, 1'b1}});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].cfg) write_sum_mode(plan[i].val[0]);
			else send_cmd(plan[i].op, plan[i].at, plan[i].val, plan[i].typed, plan[i].want, 1'b0);
		end

		for (int ph = 0; ph < 5; ph++) begin
			write_sum_mode(ph == 4 ? 1'($urandom_range(0, 1)) : ph[0]);
			flat = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 90; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) op = MODE_SET;
				else if (pick < 45) op = MODE_ADD;
				else if (pick < 60) op = MODE_SET_UPD;
				else if (pick < 76) op = MODE_UPD;
				else if (pick < 90) op = MODE_READ;
				else if (pick < 95) op = pick[0] ? MODE_SPARE_LO : MODE_SPARE_HI;
				else op = MODE_CLEAR;
				case ($urandom_range(0, 3))
					0: at = 48'($urandom_range(0, 239));
					1: at = {16'($urandom), 32'($urandom)};
					2: at = 48'hffff_ffff_ffff - 48'($urandom_range(0, 59));
					default: at = 48'($urandom_range(0, 12959999));
				endcase
				case ($urandom_range(0, 4))
					0: val = $urandom;
					1: val = 32'($urandom_range(0, 32'h001fffff)) - 32'h00100000;
					2: val = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
					3: val = {1'b0, 31'($urandom)};
					default: val = $urandom;
				endcase
				send_cmd(op, at, val, 1'b0, '0, flat);
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (320) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
